>>> src/cds_pkg.sv
// Shared constants, op codes and month-length helper for the calendar date stepper.
`default_nettype none

package cds_pkg;

    // Field widths fixed by the date format
    localparam int CDS_YEAR_WIDTH = 10;
    localparam int MONTH_W        = 4;
    localparam int DAY_W          = 5;
    localparam int OP_W           = 3;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [DAY_W-1:0]   t_day;

    // Step operation codes
    localparam t_op OP_DAY_BACK   = 3'd0;
    localparam t_op OP_MONTH_BACK = 3'd1;
    localparam t_op OP_YEAR_BACK  = 3'd2;
    localparam t_op OP_DAY_FWD    = 3'd3;
    localparam t_op OP_MONTH_FWD  = 3'd4;
    localparam t_op OP_YEAR_FWD   = 3'd5;

    // Months with special lengths
    localparam t_month MONTH_JAN = 4'd0;
    localparam t_month MONTH_FEB = 4'd1;
    localparam t_month MONTH_APR = 4'd3;
    localparam t_month MONTH_JUN = 4'd5;
    localparam t_month MONTH_SEP = 4'd8;
    localparam t_month MONTH_NOV = 4'd10;
    localparam t_month MONTH_DEC = 4'd11;

    localparam t_day LEN_LEAP_FEB = 5'd29;
    localparam t_day LEN_FEB      = 5'd28;
    localparam t_day LEN_SHORT    = 5'd30;
    localparam t_day LEN_LONG     = 5'd31;

    // Days in a month; leap is set when the year count is a multiple of four.
    // Any month code above December counts as a long month.
    function automatic t_day month_len(input logic leap, input t_month month);
        t_day len;
        if (month == MONTH_FEB) begin
            len = leap ? LEN_LEAP_FEB : LEN_FEB;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = LEN_SHORT;
        end else begin
            len = LEN_LONG;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> src/cds_step.sv
// Combinational date step: applies one day, month or year move to a registered date.
`default_nettype none

module cds_step #(
    parameter int YEAR_WIDTH = cds_pkg::CDS_YEAR_WIDTH
) (
    input  wire cds_pkg::t_op    i_op,
    input  wire [YEAR_WIDTH-1:0] i_year,
    input  wire cds_pkg::t_month i_month,
    input  wire cds_pkg::t_day   i_day,
    output logic [YEAR_WIDTH-1:0] o_new_year,
    output cds_pkg::t_month       o_new_month,
    output cds_pkg::t_day         o_new_day,
    output logic                  o_year_wrapped
);
    import cds_pkg::*;

    localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};

    logic [YEAR_WIDTH-1:0] w_year_dn;
    logic [YEAR_WIDTH-1:0] w_year_up;
    logic                  w_dn_wrap;
    logic                  w_up_wrap;
    t_month                w_month_dn;
    t_month                w_month_up;
    logic                  w_dn_year_chg;
    logic                  w_up_year_chg;
    logic [YEAR_WIDTH-1:0] w_prev_year;
    t_day                  w_prev_len;
    t_day                  w_cur_len;
    logic                  w_day_low;
    logic                  w_day_over;

    // Neighboring years with wrap detection
    assign w_dn_wrap = (i_year == '0);
    assign w_up_wrap = (i_year == YEAR_MAX);
    assign w_year_dn = w_dn_wrap ? YEAR_MAX : i_year - YEAR_WIDTH'(1);
    assign w_year_up = w_up_wrap ? '0 : i_year + YEAR_WIDTH'(1);

    // Neighboring months; forward from December or beyond rolls the year
    assign w_dn_year_chg = (i_month == MONTH_JAN);
    assign w_up_year_chg = (i_month >= MONTH_DEC);
    assign w_month_dn    = w_dn_year_chg ? MONTH_DEC : i_month - 4'd1;
    assign w_month_up    = w_up_year_chg ? MONTH_JAN : i_month + 4'd1;

    // Month lengths for the current and the previous month
    assign w_prev_year = w_dn_year_chg ? w_year_dn : i_year;
    assign w_prev_len  = month_len(w_prev_year[1:0] == 2'b00, w_month_dn);
    assign w_cur_len   = month_len(i_year[1:0] == 2'b00, i_month);

    // Day zero or one falls back into the previous month
    assign w_day_low  = (i_day[DAY_W-1:1] == '0);
    assign w_day_over = ({1'b0, i_day} + 6'd1) > {1'b0, w_cur_len};

    // Select the result for the requested op
    always_comb begin
        o_new_year     = i_year;
        o_new_month    = i_month;
        o_new_day      = i_day;
        o_year_wrapped = 1'b0;
        unique case (i_op)
            OP_DAY_BACK: begin
                if (w_day_low) begin
                    o_new_month = w_month_dn;
                    o_new_year  = w_prev_year;
                    o_new_day   = i_day[0] ? w_prev_len : w_prev_len - 5'd1;
                    o_year_wrapped = w_dn_year_chg & w_dn_wrap;
                end else begin
                    o_new_day = i_day - 5'd1;
                end
            end
            OP_MONTH_BACK: begin
                o_new_month = w_month_dn;
                if (w_dn_year_chg) begin
                    o_new_year     = w_year_dn;
                    o_year_wrapped = w_dn_wrap;
                end
            end
            OP_YEAR_BACK: begin
                o_new_year     = w_year_dn;
                o_year_wrapped = w_dn_wrap;
            end
            OP_DAY_FWD: begin
                if (w_day_over) begin
                    o_new_month = w_month_up;
                    o_new_day   = 5'd1;
                    if (w_up_year_chg) begin
                        o_new_year     = w_year_up;
                        o_year_wrapped = w_up_wrap;
                    end
                end else begin
                    o_new_day = i_day + 5'd1;
                end
            end
            OP_MONTH_FWD: begin
                o_new_month = w_month_up;
                if (w_up_year_chg) begin
                    o_new_year     = w_year_up;
                    o_year_wrapped = w_up_wrap;
                end
            end
            OP_YEAR_FWD: begin
                o_new_year     = w_year_up;
                o_year_wrapped = w_up_wrap;
            end
            default: begin
                o_year_wrapped = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/calendar_date_stepper.sv
// Top level: input register, date step logic and result register with handshakes.
//
//  channel   | valid    | ready    | payload
//  ----------+----------+----------+-----------------------------------------------
//  date in   | i_valid  | o_ready  | i_op, i_year, i_month, i_day
//  date out  | o_valid  | i_ready  | o_new_year, o_new_month, o_new_day, o_year_wrapped
//
// One beat in per cycle while the output is not stalled, one result beat out per input beat.
// Each date passes through the input register, then the result register.
// The step logic between the two registers is a few small adders and compares.
// Synchronous active-low reset empties both registers.
// A stall on the output backs up through the result and input registers.
`default_nettype none

module calendar_date_stepper #(
    parameter int YEAR_WIDTH = cds_pkg::CDS_YEAR_WIDTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire cds_pkg::t_op     i_op,
    input  wire [YEAR_WIDTH-1:0]  i_year,
    input  wire cds_pkg::t_month  i_month,
    input  wire cds_pkg::t_day    i_day,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [YEAR_WIDTH-1:0] o_new_year,
    output cds_pkg::t_month       o_new_month,
    output cds_pkg::t_day         o_new_day,
    output logic                  o_year_wrapped
);
    import cds_pkg::*;

    logic                  r_in_valid;
    logic                  n_in_valid;
    t_op                   r_op;
    logic [YEAR_WIDTH-1:0] r_year;
    t_month                r_month;
    t_day                  r_day;

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [YEAR_WIDTH-1:0] r_new_year;
    t_month                r_new_month;
    t_day                  r_new_day;
    logic                  r_year_wrapped;

    logic                  w_adv;
    logic                  w_in_take;
    logic [YEAR_WIDTH-1:0] w_new_year;
    t_month                w_new_month;
    t_day                  w_new_day;
    logic                  w_year_wrapped;

    // Advance the input stage when the result register is free or draining
    assign w_adv     = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || w_adv;
    assign w_in_take = i_valid && o_ready;

    assign n_in_valid  = w_in_take ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
    assign n_out_valid = w_adv ? r_in_valid : r_out_valid;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the incoming date beat
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= i_op;
            r_year  <= i_year;
            r_month <= i_month;
            r_day   <= i_day;
        end
    end

    cds_step #(
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_step (
        .i_op           (r_op),
        .i_year         (r_year),
        .i_month        (r_month),
        .i_day          (r_day),
        .o_new_year     (w_new_year),
        .o_new_month    (w_new_month),
        .o_new_day      (w_new_day),
        .o_year_wrapped (w_year_wrapped)
    );

    // Hold the result until the output beat is taken
    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_new_year     <= w_new_year;
            r_new_month    <= w_new_month;
            r_new_day      <= w_new_day;
            r_year_wrapped <= w_year_wrapped;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_new_year     = r_new_year;
    assign o_new_month    = r_new_month;
    assign o_new_day      = r_new_day;
    assign o_year_wrapped = r_year_wrapped;

    // Input only stalls when both stages are full and the output is blocked
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled without a full pipeline");

    // An accepted beat lands in the input stage
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid)
        else $error("accepted beat lost at input stage");

    // A moving input stage fills the result register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv) |=> r_out_valid)
        else $error("result register missed a beat");

    // A wrap flag only comes with a year at either end of its range
    a_wrap_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_year_wrapped) |->
            (o_new_year == '0 || o_new_year == {YEAR_WIDTH{1'b1}}))
        else $error("wrap flag with an inner year");

endmodule

`default_nettype wire
